@@ hdl/sbbf_pkg.sv @@
// Package for the split block Bloom filter core.
// Holds the operation codes, the controller states, the salt table and the
// hash-position bundle. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sbbf_pkg;

	// Geometry of one filter block.
	localparam int WORDS_PER_BLOCK = 8;
	localparam int WORD_W          = 32;
	localparam int BLOCK_W         = WORDS_PER_BLOCK * WORD_W;
	localparam int POS_W           = 5;
	localparam int SHIFT_TOP5      = 27;
	localparam int COUNT_W         = 11;

	// Operation codes carried by an input beat.
	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_CHECK  = 3'd1,
		OP_LOAD   = 3'd2,
		OP_MERGE  = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_MODIFY
	} state_t;

	// Salt applied to the low hash word for each word of a block.
	localparam logic [WORD_W-1:0] SALT [WORDS_PER_BLOCK] = '{
		32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
		32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
	};

	// Block index and per-word bit positions derived from one hash.
	typedef struct packed {
		logic [COUNT_W-1:0]                  blk_idx;
		logic [WORDS_PER_BLOCK-1:0][POS_W-1:0] pos;
	} hash_pos_t;

endpackage

`default_nettype wire

@@ hdl/sbbf_mem.sv @@
// Filter block store: one write port and one read port, registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module sbbf_mem #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 256
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/sbbf_hash.sv @@
// Hash decode: block index from the high hash word and one bit position per
// word from the salted low hash word. Uses types and the salt table of sbbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbbf_hash import sbbf_pkg::*; (
	input  wire logic [63:0]        hash,
	input  wire logic [COUNT_W-1:0] eff_blocks,
	output hash_pos_t               hp
);

	logic [32+COUNT_W-1:0] blk_prod;
	logic [WORD_W-1:0]     salt_prod [WORDS_PER_BLOCK];

	// Block index is the high half of (hash high word times block count).
	assign blk_prod   = {{COUNT_W{1'b0}}, hash[63:32]} * {32'd0, eff_blocks};
	assign hp.blk_idx = blk_prod[32+COUNT_W-1:32];

	// Each lane keeps the top five bits of a wrapping 32-bit product.
	for (genvar i = 0; i < WORDS_PER_BLOCK; i++) begin : g_lane
		assign salt_prod[i] = SALT[i] * hash[31:0];
		assign hp.pos[i]    = salt_prod[i][WORD_W-1:SHIFT_TOP5];
	end

endmodule

`default_nettype wire

@@ hdl/split_block_bloom_filter_core.sv @@
// Top level of the split block Bloom filter core: controller, output register
// and configuration. Uses sbbf_pkg, sbbf_hash and sbbf_mem.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall   | operation, hash, word_address, word_data
//  out     | output    | out_valid / out_stall | maybe_present, read_word
//  cfg     | input     | cfg_we                | cfg_wdata (block_count)
//
// Each beat goes through accept, decode and block read, then modify and write
// back; the single read-modify-write of one 256-bit block sets this.
// After reset a clearing pass writes zero to all MAX_BLOCKS blocks, one per
// cycle, with in_stall high; configuration writes are taken throughout.
// A beat may be accepted while a result waits; a stalled output holds the next
// beat in its write-back cycle until the waiting result is taken.
`timescale 1ns / 1ps
`default_nettype none

module split_block_bloom_filter_core import sbbf_pkg::*; #(
	parameter int MAX_BLOCKS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  operation,
	input  wire logic [63:0] hash,
	input  wire logic [12:0] word_address,
	input  wire logic [31:0] word_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             maybe_present,
	output logic [31:0]      read_word
);

	localparam int BLK_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam logic [COUNT_W-1:0] MaxBlkCnt =
		(MAX_BLOCKS > 2047) ? 11'd2047 : COUNT_W'(MAX_BLOCKS);
	localparam logic [BLK_W-1:0] LastBlk = BLK_W'(MAX_BLOCKS - 1);

	state_t state_q, state_d;

	logic [COUNT_W-1:0] block_count_q;
	logic [COUNT_W-1:0] eff_blocks;
	logic [BLK_W-1:0]   clr_cnt_q;

	logic [2:0]  op_q;
	logic [63:0] hash_q;
	logic [12:0] addr_q;
	logic [31:0] data_q;

	hash_pos_t                             hp;
	logic [WORDS_PER_BLOCK-1:0][POS_W-1:0] pos_q;
	logic [BLK_W-1:0]                      blk_q;
	logic                                  in_range_q;
	logic [BLK_W-1:0]                      rd_blk;

	logic                                     mem_wr_en;
	logic [BLK_W-1:0]                         mem_wr_addr;
	logic [BLOCK_W-1:0]                       mem_wr_data;
	logic                                     mem_rd_en;
	logic [WORDS_PER_BLOCK-1:0][WORD_W-1:0]   blk_rd;
	logic [WORDS_PER_BLOCK-1:0][WORD_W-1:0]   blk_new;
	logic                                     blk_write;
	logic                                     present;
	logic [WORD_W-1:0]                        rd_word;

	logic advance;
	logic out_valid_q;
	logic maybe_present_q;
	logic [31:0] read_word_q;

	// Configuration register and its clamped value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= 11'd1;
		end else if (cfg_we) begin
			block_count_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (block_count_q == '0) begin
			eff_blocks = 11'd1;
		end else if (block_count_q > MaxBlkCnt) begin
			eff_blocks = MaxBlkCnt;
		end else begin
			eff_blocks = block_count_q;
		end
	end

	// Hash decode works on the captured beat.
	sbbf_hash u_hash (
		.hash       (hash_q),
		.eff_blocks (eff_blocks),
		.hp         (hp)
	);

	// Read address: hashed block or the block part of a word address.
	always_comb begin
		if (op_q == OP_INSERT || op_q == OP_CHECK) begin
			rd_blk = BLK_W'(hp.blk_idx);
		end else begin
			rd_blk = BLK_W'(addr_q[12:3]);
		end
	end

	// The modify stage may finish once the output register is free.
	assign advance = !out_valid_q || !out_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == LastBlk) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_HASH;
			end
			ST_HASH: begin
				state_d = ST_MODIFY;
			end
			ST_MODIFY: begin
				if (advance) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Controller outputs.
	always_comb begin
		in_stall    = 1'b1;
		mem_rd_en   = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = blk_q;
		mem_wr_data = blk_new;
		case (state_q)
			ST_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = clr_cnt_q;
				mem_wr_data = '0;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_HASH: begin
				mem_rd_en = 1'b1;
			end
			ST_MODIFY: begin
				mem_wr_en = advance && blk_write;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Capture the accepted beat.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q   <= operation;
			hash_q <= hash;
			addr_q <= word_address;
			data_q <= word_data;
		end
	end

	// Decode results held for the modify stage.
	always_ff @(posedge clk) begin
		if (state_q == ST_HASH) begin
			pos_q      <= hp.pos;
			blk_q      <= rd_blk;
			in_range_q <= {1'b0, addr_q} < {eff_blocks, 3'b000};
		end
	end

	sbbf_mem #(
		.DEPTH  (MAX_BLOCKS),
		.ADDR_W (BLK_W),
		.DATA_W (BLOCK_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (rd_blk),
		.rd_data (blk_rd)
	);

	// Modify the block that was read and form the result.
	always_comb begin
		blk_new   = blk_rd;
		blk_write = 1'b0;
		present   = 1'b0;
		rd_word   = '0;
		case (op_q)
			OP_INSERT: begin
				blk_write = 1'b1;
				for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
					blk_new[i][pos_q[i]] = 1'b1;
				end
			end
			OP_CHECK: begin
				present = 1'b1;
				for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
					if (!blk_rd[i][pos_q[i]]) present = 1'b0;
				end
			end
			OP_LOAD: begin
				blk_write           = in_range_q;
				blk_new[addr_q[2:0]] = data_q;
			end
			OP_MERGE: begin
				blk_write           = in_range_q;
				blk_new[addr_q[2:0]] = blk_rd[addr_q[2:0]] | data_q;
			end
			OP_READ: begin
				if (in_range_q) rd_word = blk_rd[addr_q[2:0]];
			end
			default: begin
				blk_write = 1'b0;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_MODIFY && advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MODIFY && advance) begin
			maybe_present_q <= present;
			read_word_q     <= rd_word;
		end
	end

	assign out_valid     = out_valid_q;
	assign maybe_present = maybe_present_q;
	assign read_word     = read_word_q;

endmodule

`default_nettype wire

@@ hdl/sbbf_checker.sv @@
// Port-level checks for split_block_bloom_filter_core, and the bind that
// attaches them. Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module sbbf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        maybe_present,
	input wire logic [31:0] read_word
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(maybe_present) && $stable(read_word))
		else $error("result payload changed while stalled");

	// Only one kind of result is ever reported in a beat.
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(maybe_present && read_word != 32'd0))
		else $error("check and read results both set");

	// One beat is worked at a time: an accept is followed by a stall.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat accepted back to back");

endmodule

bind split_block_bloom_filter_core sbbf_checker u_sbbf_checker (.*);

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for split_block_bloom_filter_core.
// It runs a directed table and then random phases over several block counts, and it checks every
// result against a fixed answer or a behavioral model. It depends on sbbf_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
	import sbbf_pkg::*;

	localparam int FILTER_BLOCKS = 1024;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 16;
	localparam int PHASE_BEATS   = 127;
	localparam int PHASE_COUNT   = 11;
	localparam int POOL_DEPTH    = 64;

	// Operation codes that the core does not define.
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	// Multipliers that pick the bit in each word of a block.
	localparam bit [31:0] SALT_MUL [8] = '{
		32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
		32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
	};

	typedef struct packed {
		bit [2:0]  op;
		bit [63:0] hash;
		bit [12:0] addr;
		bit [31:0] data;
	} beat_t;

	typedef struct packed {
		bit        present;
		bit [31:0] word;
	} answer_t;

	typedef struct packed {
		beat_t   beat;
		bit      fixed;
		answer_t answer;
	} dir_row_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_we       = 1'b0;
	logic [10:0] cfg_wdata    = '0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [2:0]  operation    = '0;
	logic [63:0] hash         = '0;
	logic [12:0] word_address = '0;
	logic [31:0] word_data    = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic        maybe_present;
	logic [31:0] read_word;

	// Model of the filter store and of the block count register.
	bit [31:0] filter_words [FILTER_BLOCKS][8];
	bit [10:0] model_block_count = 11'd1;

	answer_t   pending_answers [$];
	dir_row_t  directed_rows [$];
	bit [63:0] hash_pool [$];

	int unsigned error_count   = 0;
	int unsigned results_seen  = 0;
	int unsigned insert_count  = 0;
	int unsigned check_count   = 0;
	int unsigned hit_count     = 0;
	int unsigned word_op_count = 0;
	int unsigned rsvd_count    = 0;
	int unsigned burst_left    = 0;
	bit          long_hold_req = 1'b0;
	bit          hold_active   = 1'b0;

	split_block_bloom_filter_core #(
		.MAX_BLOCKS(FILTER_BLOCKS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.hash         (hash),
		.word_address (word_address),
		.word_data    (word_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.maybe_present(maybe_present),
		.read_word    (read_word)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// A count of zero behaves as one block, and a count above the store is clamped.
	function automatic int unsigned blocks_in_use();
		if (model_block_count == 0)
			return 1;
		if (model_block_count > FILTER_BLOCKS)
			return FILTER_BLOCKS;
		return model_block_count;
	endfunction

	function automatic int unsigned block_for_hash(bit [63:0] h);
		bit [63:0] prod;
		bit [63:0] n;
		n = blocks_in_use();
		prod = {32'd0, h[63:32]} * n;
		if (prod[63:32] >= FILTER_BLOCKS)
			return FILTER_BLOCKS - 1;
		return prod[63:32];
	endfunction

	function automatic bit [31:0] salted_bit(bit [31:0] key, int i);
		bit [31:0] prod;
		prod = SALT_MUL[i] * key;
		return 32'd1 << prod[31:27];
	endfunction

	// Applies one beat to the model filter and returns the result it should produce.
	function automatic answer_t bloom_apply(beat_t b);
		answer_t     a;
		int unsigned blk;
		int unsigned lim;
		a = '0;
		case (b.op)
			OP_INSERT: begin
				blk = block_for_hash(b.hash);
				for (int i = 0; i < 8; i++)
					filter_words[blk][i] |= salted_bit(b.hash[31:0], i);
			end
			OP_CHECK: begin
				blk = block_for_hash(b.hash);
				a.present = 1'b1;
				for (int i = 0; i < 8; i++)
					if ((filter_words[blk][i] & salted_bit(b.hash[31:0], i)) == 0)
						a.present = 1'b0;
			end
			OP_LOAD, OP_MERGE, OP_READ: begin
				lim = blocks_in_use() * 8;
				if (b.addr < lim) begin
					if (b.op == OP_LOAD)
						filter_words[b.addr[12:3]][b.addr[2:0]] = b.data;
					else if (b.op == OP_MERGE)
						filter_words[b.addr[12:3]][b.addr[2:0]] |= b.data;
					else
						a.word = filter_words[b.addr[12:3]][b.addr[2:0]];
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	// Mostly inserts and checks of recently inserted hashes, with word traffic and noise.
	function automatic beat_t random_beat();
		beat_t       b;
		int unsigned roll;
		int unsigned lim;
		int unsigned pick;
		b.hash = {$urandom, $urandom};
		b.addr = $urandom_range(0, 8191);
		b.data = $urandom;
		roll = $urandom_range(0, 99);
		lim = blocks_in_use() * 8;
		if (roll < 30) begin
			b.op = OP_INSERT;
			hash_pool.push_back(b.hash);
			if (hash_pool.size() > POOL_DEPTH)
				void'(hash_pool.pop_front());
		end else if (roll < 65) begin
			b.op = OP_CHECK;
			if (roll < 55 && hash_pool.size() > 0)
				b.hash = hash_pool[$urandom_range(0, hash_pool.size() - 1)];
		end else if (roll < 95) begin
			b.op = (roll < 75) ? OP_LOAD : (roll < 83) ? OP_MERGE : OP_READ;
			pick = $urandom_range(0, 9);
			if (pick < 6)
				b.addr = $urandom_range(0, lim - 1);
			else if (pick < 8 && hash_pool.size() > 0)
				b.addr = block_for_hash(hash_pool[$urandom_range(0, hash_pool.size() - 1)]) * 8
					+ $urandom_range(0, 7);
			pick = $urandom_range(0, 7);
			if (pick == 0)
				b.data = '0;
			else if (pick == 1)
				b.data = '1;
		end else begin
			b.op = $urandom_range(OP_RSVD5, OP_RSVD7);
		end
		return b;
	endfunction

	task automatic add_row(bit [2:0] op, bit [63:0] h, bit [12:0] addr, bit [31:0] data,
			bit fixed, bit present, bit [31:0] word);
		dir_row_t r;
		r.beat = '{op: op, hash: h, addr: addr, data: data};
		r.fixed = fixed;
		r.answer = '{present: present, word: word};
		directed_rows.push_back(r);
	endtask

	// Offers one beat, waits for it to be taken, then records what it should return.
	task automatic send_beat(beat_t b, bit fixed, answer_t fixed_answer);
		answer_t predicted;
		in_valid     <= 1'b1;
		operation    <= b.op;
		hash         <= b.hash;
		word_address <= b.addr;
		word_data    <= b.data;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predicted = bloom_apply(b);
		pending_answers.push_back(fixed ? fixed_answer : predicted);
		case (b.op)
			OP_INSERT: insert_count++;
			OP_CHECK: begin
				check_count++;
				if (predicted.present)
					hit_count++;
			end
			OP_LOAD, OP_MERGE, OP_READ: word_op_count++;
			default: rsvd_count++;
		endcase
	endtask

	// Drops valid for a while and scrambles the idle payload.
	task automatic pause_sender(int unsigned cycles);
		in_valid     <= 1'b0;
		operation    <= $urandom;
		hash         <= {$urandom, $urandom};
		word_address <= $urandom;
		word_data    <= $urandom;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic pace_sender();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 8));
		end
		burst_left--;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_block_count(bit [10:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_block_count = value;
	endtask

	// Receiver stall pattern, with one long hold-off when the stimulus asks for it.
	initial begin : rx_stall
		int unsigned seg_len;
		int unsigned mode;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				hold_active = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
				hold_active = 1'b0;
			end else begin
				seg_len = $urandom_range(1, 40);
				mode = $urandom_range(0, 3);
				repeat (seg_len) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= ($urandom_range(0, 9) < 6);
						default: out_stall <= ~out_stall;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Compares every result beat with the oldest expectation.
	always @(posedge clk) begin : result_check
		answer_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected result beat, maybe_present=%b read_word=%h",
					$time, maybe_present, read_word);
				error_count++;
			end else begin
				want = pending_answers.pop_front();
				if (maybe_present !== want.present) begin
					$display("%0t: maybe_present expected %b, got %b",
						$time, want.present, maybe_present);
					error_count++;
				end
				if (read_word !== want.word) begin
					$display("%0t: read_word expected %h, got %h", $time, want.word, read_word);
					error_count++;
				end
			end
		end
	end

	initial begin : stimulus
		bit [10:0] settings [PHASE_COUNT];
		answer_t   none;
		none = '0;
		settings = '{11'd3, 11'd1024, 11'd0, 11'd2047, 11'd1, 11'd2, 11'd1025,
			11'd9, 11'd700, 11'd17, 11'd5};
		settings[7] = $urandom_range(1, 16);
		settings[8] = $urandom_range(1, 2047);

		// Directed table at the reset block count of one.
		add_row(OP_CHECK, 64'd0, 13'd0, 32'd0, 1'b1, 1'b0, 32'd0);
		add_row(OP_READ, 64'd0, 13'd0, 32'd0, 1'b1, 1'b0, 32'd0);
		add_row(OP_READ, 64'd0, 13'd8191, 32'd0, 1'b1, 1'b0, 32'd0);
		add_row(OP_INSERT, 64'd0, 13'd0, 32'd0, 1'b1, 1'b0, 32'd0);
		add_row(OP_CHECK, 64'd0, 13'd0, 32'd0, 1'b1, 1'b1, 32'd0);
		add_row(OP_READ, 64'd0, 13'd0, 32'd0, 1'b0, 1'b0, 32'd0);
		add_row(OP_CHECK, '1, 13'd8191, '1, 1'b0, 1'b0, 32'd0);
		add_row(OP_INSERT, '1, 13'd8191, '1, 1'b1, 1'b0, 32'd0);
		add_row(OP_CHECK, '1, 13'd8191, '1, 1'b1, 1'b1, 32'd0);
		// Word addresses past the configured size are dropped and read as zero.
		add_row(OP_LOAD, 64'd0, 13'd8, '1, 1'b1, 1'b0, 32'd0);
		add_row(OP_READ, 64'd0, 13'd8, 32'd0, 1'b1, 1'b0, 32'd0);
		add_row(OP_LOAD, 64'd0, 13'd3, 32'd0, 1'b1, 1'b0, 32'd0);
		add_row(OP_CHECK, '1, 13'd0, 32'd0, 1'b1, 1'b0, 32'd0);
		add_row(OP_MERGE, 64'd0, 13'd3, 32'h8000_0001, 1'b1, 1'b0, 32'd0);
		add_row(OP_READ, 64'd0, 13'd3, 32'd0, 1'b1, 1'b0, 32'h8000_0001);
		add_row(OP_MERGE, 64'd0, 13'd8191, '1, 1'b1, 1'b0, 32'd0);
		add_row(OP_LOAD, 64'd0, 13'd7, '1, 1'b1, 1'b0, 32'd0);
		add_row(OP_READ, 64'd0, 13'd7, 32'd0, 1'b1, 1'b0, '1);
		// Undefined codes change nothing and return zeros.
		add_row(OP_RSVD5, '1, 13'd0, '1, 1'b1, 1'b0, 32'd0);
		add_row(OP_RSVD6, '1, 13'd7, '1, 1'b1, 1'b0, 32'd0);
		add_row(OP_RSVD7, '1, 13'd3, '1, 1'b1, 1'b0, 32'd0);
		add_row(OP_READ, 64'd0, 13'd5, 32'd0, 1'b0, 1'b0, 32'd0);
		add_row(OP_CHECK, 64'h0123_4567_89ab_cdef, 13'd0, 32'd0, 1'b0, 1'b0, 32'd0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed_rows[r])
			send_beat(directed_rows[r].beat, directed_rows[r].fixed, directed_rows[r].answer);

		// Random phases, each at its own block count, written while the core is idle.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain_results();
			write_block_count(settings[p]);
			if (p == 3) begin
				// Back-to-back beats against a long output hold-off fill the core.
				long_hold_req = 1'b1;
				while (!hold_active)
					@(posedge clk);
				repeat (40) send_beat(random_beat(), 1'b0, none);
			end
			repeat (PHASE_BEATS) begin
				pace_sender();
				send_beat(random_beat(), 1'b0, none);
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d inserts, %0d checks (%0d hits), %0d word ops, %0d undefined codes",
			insert_count, check_count, hit_count, word_op_count, rsvd_count);
		$display("over %0d block-count settings; %0d result beats compared, %0d errors.",
			PHASE_COUNT, results_seen, error_count);
		if (error_count == 0 && pending_answers.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/sbbf_pkg.sv
hdl/sbbf_mem.sv
hdl/sbbf_hash.sv
hdl/split_block_bloom_filter_core.sv
hdl/sbbf_checker.sv
sim/tb.sv
